[src/stsb_pkg.sv]
// Shared types and constants for the sorted table binary search unit.
// Depends on nothing; every other file in src imports it.
package stsb_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [IDX_W-1:0]     entry_index;
        logic [KEY_WIDTH-1:0] key_low;
        logic [KEY_WIDTH-1:0] key_high;
        logic [CNT_W-1:0]     match_limit;
    } t_in_item;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] hit_index;
        logic [CNT_W-1:0] match_count;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_FIND,
        PH_LOWER,
        PH_UPPER
    } t_phase;

endpackage

[src/sorted_table_binary_search_unit.sv]
// Sorted key table with binary search: exact find and bounded range query.
// Find: one pass of read-then-compare steps; range: two passes of read-then-compare
// steps, one comparator.
// A lookup holds the input until its result is registered; the next item goes in the cycle after.
// A result waits in an output register while the next item runs.
// Synchronous active-low reset clears control state and entry_count; keys undefined until written.
module sorted_table_binary_search_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  stsb_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output stsb_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [stsb_pkg::CNT_W-1:0] i_cfg_data
);
    import stsb_pkg::*;

    logic [CNT_W-1:0]     r_entry_count;
    logic [CNT_W-1:0]     count_clamped;
    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic                 in_accept;
    logic                 seq_idle;
    logic                 res_valid;
    logic                 res_ready;
    t_out_item            res_item;
    logic [IDX_W-1:0]     raddr;
    logic [KEY_WIDTH-1:0] rdata;
    logic                 ram_we;
    logic                 seq_start;

    assign o_in_stall  = !seq_idle;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign ram_we      = in_accept && (i_in_item.cmd == CMD_WRITE);
    assign seq_start   = in_accept &&
                         ((i_in_item.cmd == CMD_FIND) || (i_in_item.cmd == CMD_RANGE));
    assign o_cfg_ready = 1'b1;
    assign count_clamped = (r_entry_count > CNT_W'(TABLE_DEPTH)) ?
                           CNT_W'(TABLE_DEPTH) : r_entry_count;

    // take the result whenever the output register is free or draining
    assign res_ready   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    stsb_key_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_item.entry_index),
        .i_wdata (i_in_item.key_low),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    stsb_search_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (seq_start),
        .i_item      (i_in_item),
        .i_count     (count_clamped),
        .o_idle      (seq_idle),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_entry_count <= i_cfg_data;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
        // hold the payload while a transaction is stalled
        if (res_ready && res_valid) begin
            r_out_item <= res_item;
        end
    end

endmodule

[src/stsb_key_ram.sv]
// Key table storage: one write port, one read port with registered data.
// Depends on stsb_pkg for depth and key width.
module stsb_key_ram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [stsb_pkg::IDX_W-1:0]     i_waddr,
    input  logic [stsb_pkg::KEY_WIDTH-1:0] i_wdata,
    input  logic [stsb_pkg::IDX_W-1:0]     i_raddr,
    output logic [stsb_pkg::KEY_WIDTH-1:0] o_rdata
);
    import stsb_pkg::*;

    logic [KEY_WIDTH-1:0] r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[src/stsb_search_seq.sv]
// Search sequencer: midpoint stepping with one shared key comparator,
// running exact find, lower bound and upper bound passes. Uses stsb_pkg.
module stsb_search_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  stsb_pkg::t_in_item             i_item,
    input  logic [stsb_pkg::CNT_W-1:0]     i_count,
    output logic                           o_idle,
    output logic [stsb_pkg::IDX_W-1:0]     o_raddr,
    input  logic [stsb_pkg::KEY_WIDTH-1:0] i_rdata,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output stsb_pkg::t_out_item            o_res
);
    import stsb_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [CNT_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]     r_hi_x, n_hi_x;      // one past the upper search limit
    logic [IDX_W-1:0]     r_mid, n_mid;
    logic [IDX_W-1:0]     r_ans, n_ans;
    logic                 r_ans_ok, n_ans_ok;
    logic [IDX_W-1:0]     r_lb, n_lb;
    logic                 r_lb_ok, n_lb_ok;
    logic [KEY_WIDTH-1:0] r_key_low, n_key_low;
    logic [KEY_WIDTH-1:0] r_key_high, n_key_high;
    logic [CNT_W-1:0]     r_limit, n_limit;

    logic [CNT_W-1:0]     mid_full;
    logic [KEY_WIDTH-1:0] cmp_key;
    logic                 key_lt;
    logic                 key_eq;
    logic                 range_ok;
    logic [CNT_W-1:0]     range_n;

    // midpoint of [lo, hi_x - 1], rounded down
    assign mid_full = r_lo + ((r_hi_x - r_lo - CNT_W'(1)) >> 1);
    assign o_raddr  = mid_full[IDX_W-1:0];

    // shared comparator
    assign cmp_key = (r_phase == PH_UPPER) ? r_key_high : r_key_low;
    assign key_lt  = i_rdata < cmp_key;
    assign key_eq  = i_rdata == cmp_key;

    assign range_ok = r_lb_ok && r_ans_ok && (r_ans >= r_lb);
    assign range_n  = {1'b0, r_ans} - {1'b0, r_lb} + CNT_W'(1);

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);

    always_comb begin
        o_res = '0;
        if (r_phase == PH_FIND) begin
            o_res.status    = r_ans_ok;
            o_res.hit_index = r_ans_ok ? r_ans : '0;
        end else if (range_ok) begin
            o_res.status      = 1'b1;
            o_res.hit_index   = r_lb;
            o_res.match_count = (range_n < r_limit) ? range_n : r_limit;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_lo       = r_lo;
        n_hi_x     = r_hi_x;
        n_mid      = r_mid;
        n_ans      = r_ans;
        n_ans_ok   = r_ans_ok;
        n_lb       = r_lb;
        n_lb_ok    = r_lb_ok;
        n_key_low  = r_key_low;
        n_key_high = r_key_high;
        n_limit    = r_limit;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_key_low  = i_item.key_low;
                    n_key_high = i_item.key_high;
                    n_limit    = i_item.match_limit;
                    n_phase    = (i_item.cmd == CMD_RANGE) ? PH_LOWER : PH_FIND;
                    n_lo       = '0;
                    n_hi_x     = i_count;
                    n_ans_ok   = 1'b0;
                    n_lb_ok    = 1'b0;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                if (r_lo >= r_hi_x) begin
                    // interval exhausted: close this pass
                    if (r_phase == PH_LOWER) begin
                        n_lb     = r_ans;
                        n_lb_ok  = r_ans_ok;
                        n_ans_ok = 1'b0;
                        n_lo     = '0;
                        n_hi_x   = i_count;
                        n_phase  = PH_UPPER;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_mid   = mid_full[IDX_W-1:0];
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_READ;
                case (r_phase)
                    PH_FIND: begin
                        if (key_eq) begin
                            n_ans    = r_mid;
                            n_ans_ok = 1'b1;
                            n_state  = ST_DONE;
                        end else if (key_lt) begin
                            n_lo = {1'b0, r_mid} + CNT_W'(1);
                        end else begin
                            n_hi_x = {1'b0, r_mid};
                        end
                    end
                    PH_LOWER: begin
                        if (!key_lt) begin
                            n_ans    = r_mid;
                            n_ans_ok = 1'b1;
                            n_hi_x   = {1'b0, r_mid};
                        end else begin
                            n_lo = {1'b0, r_mid} + CNT_W'(1);
                        end
                    end
                    default: begin
                        if (key_lt || key_eq) begin
                            n_ans    = r_mid;
                            n_ans_ok = 1'b1;
                            n_lo     = {1'b0, r_mid} + CNT_W'(1);
                        end else begin
                            n_hi_x = {1'b0, r_mid};
                        end
                    end
                endcase
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_FIND;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
        r_lo       <= n_lo;
        r_hi_x     <= n_hi_x;
        r_mid      <= n_mid;
        r_ans      <= n_ans;
        r_ans_ok   <= n_ans_ok;
        r_lb       <= n_lb;
        r_lb_ok    <= n_lb_ok;
        r_key_low  <= n_key_low;
        r_key_high <= n_key_high;
        r_limit    <= n_limit;
    end

endmodule

[test/tb.sv]
// Testbench for sorted_table_binary_search_unit: table loads, exact finds and range queries.
// Checks every result against a behavioural predictor under random idling and output hold-off.
// Depends on stsb_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
    import stsb_pkg::*;

    localparam logic [1:0]           CMD_UNUSED   = 2'd3;
    localparam int                   DRAIN_CYCLES = 64;
    localparam int                   HOLD_CYCLES  = 300;
    localparam logic [KEY_WIDTH-1:0] KEY_MAX      = '1;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // Predictor state
    logic [KEY_WIDTH-1:0] shadow_keys [TABLE_DEPTH];
    logic [CNT_W-1:0]     shadow_count;
    t_out_item            lookups_pending [$];
    t_out_item            lookup_due;

    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_output;

    sorted_table_binary_search_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int live_entries();
        return (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    endfunction

    function automatic int find_slot(input logic [KEY_WIDTH-1:0] key);
        int lo, hi, mid;
        lo = 0;
        hi = live_entries() - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] == key) return mid;
            if (shadow_keys[mid] < key) lo = mid + 1;
            else hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic int first_at_or_above(input logic [KEY_WIDTH-1:0] bound);
        int lo, hi, mid, ans;
        lo  = 0;
        hi  = live_entries() - 1;
        ans = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] >= bound) begin
                ans = mid;
                hi  = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return ans;
    endfunction

    function automatic int last_at_or_below(input logic [KEY_WIDTH-1:0] bound);
        int lo, hi, mid, ans;
        lo  = 0;
        hi  = live_entries() - 1;
        ans = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] <= bound) begin
                ans = mid;
                lo  = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return ans;
    endfunction

    function automatic t_out_item expected_lookup(input t_in_item it);
        t_out_item r;
        int        slot, first, last, span;
        r = '0;
        if (it.cmd == CMD_FIND) begin
            slot = find_slot(it.key_low);
            if (slot >= 0) begin
                r.status    = 1'b1;
                r.hit_index = slot[IDX_W-1:0];
            end
        end else begin
            first = first_at_or_above(it.key_low);
            last  = last_at_or_below(it.key_high);
            if (first >= 0 && last >= 0 && last >= first) begin
                span          = last - first + 1;
                r.status      = 1'b1;
                r.hit_index   = first[IDX_W-1:0];
                r.match_count = (span < int'(it.match_limit)) ? span[CNT_W-1:0]
                                                              : it.match_limit;
            end
        end
        return r;
    endfunction

    // Apply one accepted transaction to the shadow table or queue its result.
    task automatic note_accepted(input t_in_item it);
        case (it.cmd)
            CMD_WRITE: begin
                shadow_keys[it.entry_index] = it.key_low;
            end
            CMD_FIND, CMD_RANGE: begin
                lookups_pending.push_back(expected_lookup(it));
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100) $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (lookups_pending.size() == 0) begin
                report_mismatch("result with no lookup outstanding");
            end else begin
                lookup_due = lookups_pending.pop_front();
                if (out_item.status !== lookup_due.status)
                    report_mismatch($sformatf("status got %0b want %0b",
                                              out_item.status, lookup_due.status));
                if (out_item.hit_index !== lookup_due.hit_index)
                    report_mismatch($sformatf("hit_index got %0d want %0d",
                                              out_item.hit_index, lookup_due.hit_index));
                if (out_item.match_count !== lookup_due.match_count)
                    report_mismatch($sformatf("match_count got %0d want %0d",
                                              out_item.match_count, lookup_due.match_count));
            end
        end
    end

    // Receiver: random stall, or a long hold-off while hold_output is set.
    always @(negedge clk) begin
        out_stall <= hold_output || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------- drivers

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        note_accepted(it);
        @(negedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_count = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain every lookup, then let a full range query's worth of cycles pass.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (lookups_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_in_item make_item(input logic [1:0]           cmd,
                                           input logic [IDX_W-1:0]     idx,
                                           input logic [KEY_WIDTH-1:0] klo,
                                           input logic [KEY_WIDTH-1:0] khi,
                                           input logic [CNT_W-1:0]     limit);
        t_in_item it;
        it.cmd         = cmd;
        it.entry_index = idx;
        it.key_low     = klo;
        it.key_high    = khi;
        it.match_limit = limit;
        return it;
    endfunction

    function automatic logic [CNT_W-1:0] random_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1, 2, 3: return CNT_W'($urandom_range(1, 20));
            4:       return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
            default: return CNT_W'(TABLE_DEPTH);
        endcase
    endfunction

    // Mostly keys taken from the live table or their neighbours, so searches hit.
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        logic [KEY_WIDTH-1:0] k;
        int                   n;
        n = live_entries();
        if (n == 0) return $urandom();
        k = shadow_keys[$urandom_range(0, n - 1)];
        case ($urandom_range(0, 4))
            0, 1:    return k;
            2:       return k + 1'b1;
            3:       return k - 1'b1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [KEY_WIDTH-1:0] next_sorted_key(input logic [KEY_WIDTH-1:0] prev);
        logic [KEY_WIDTH:0] sum;
        case ($urandom_range(0, 3))
            0:       sum = {1'b0, prev};
            1:       sum = {1'b0, prev} + (KEY_WIDTH+1)'(1);
            2:       sum = {1'b0, prev} + (KEY_WIDTH+1)'($urandom_range(2, 1000));
            default: sum = {1'b0, prev} + (KEY_WIDTH+1)'($urandom_range(1000, 1 << 22));
        endcase
        return sum[KEY_WIDTH] ? KEY_MAX : sum[KEY_WIDTH-1:0];
    endfunction

    function automatic t_in_item random_lookup(input logic [1:0] cmd);
        t_in_item it;
        it = make_item(cmd, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_key(),
                       $urandom(), random_limit());
        if (cmd == CMD_RANGE) begin
            case ($urandom_range(0, 3))
                0:       it.key_high = it.key_low;
                1:       it.key_high = pick_key();
                2:       it.key_high = (KEY_MAX - it.key_low < 5000) ? KEY_MAX
                                       : it.key_low + $urandom_range(0, 5000);
                default: it.key_high = KEY_MAX;
            endcase
            if ($urandom_range(0, 7) == 0) it.key_low = '0;
        end
        return it;
    endfunction

    task automatic load_prefix(input int n, input bit ordered);
        logic [KEY_WIDTH-1:0] key;
        int                   slot;
        key = ($urandom_range(0, 3) == 0) ? '0 : ($urandom() >> $urandom_range(1, 31));
        for (slot = 0; slot < n; slot++) begin
            send_item(make_item(CMD_WRITE, IDX_W'(slot), key, $urandom(), random_limit()));
            key = ordered ? next_sorted_key(key) : KEY_WIDTH'($urandom_range(0, 15));
        end
    endtask

    // Finds and range queries, with a little noise: stray writes and unused commands.
    task automatic run_random_batch(input int lookups);
        t_in_item it;
        int       done, pick;
        done = 0;
        while (done < lookups) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      it = random_lookup(CMD_FIND);
            else if (pick < 85) it = random_lookup(CMD_RANGE);
            else if (pick < 95) it = make_item(CMD_WRITE,
                                               IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                               $urandom(), $urandom(), random_limit());
            else                it = random_lookup(CMD_UNUSED);
            send_item(it);
            if (it.cmd != CMD_UNUSED) done++;
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_empty_table();
        write_count('0);
        send_item(make_item(CMD_FIND, '0, '0, KEY_MAX, '0));
        send_item(make_item(CMD_FIND, '1, KEY_MAX, '0, '1));
        send_item(make_item(CMD_RANGE, '0, '0, KEY_MAX, CNT_W'(TABLE_DEPTH)));
        send_item(make_item(CMD_UNUSED, '1, KEY_MAX, KEY_MAX, '1));
        wait_idle();
    endtask

    // Write only the slots that a search walking to either end of a full table visits,
    // with keys rising by slot, so the queries below read written entries only.
    task automatic test_full_table();
        logic [KEY_WIDTH-1:0] key;
        int                   side, lo, hi, mid;
        for (side = 0; side < 2; side++) begin
            lo = 0;
            hi = TABLE_DEPTH - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                key = (mid == TABLE_DEPTH - 1) ? KEY_MAX : KEY_WIDTH'((mid + 1) << 16);
                send_item(make_item(CMD_WRITE, IDX_W'(mid), key, '0, '0));
                if (side == 0) hi = mid - 1;
                else lo = mid + 1;
            end
        end
        wait_idle();
        write_count(CNT_W'(TABLE_DEPTH));
        send_item(make_item(CMD_FIND, '0, '0, '0, '0));
        send_item(make_item(CMD_FIND, '0, KEY_MAX, '0, '0));
        send_item(make_item(CMD_FIND, '0, KEY_WIDTH'(1 << 16), '0, '0));
        send_item(make_item(CMD_RANGE, '0, '0, KEY_MAX, CNT_W'(TABLE_DEPTH)));
        send_item(make_item(CMD_RANGE, '0, '0, KEY_MAX, '1));
        send_item(make_item(CMD_RANGE, '0, '0, KEY_MAX, '0));
        send_item(make_item(CMD_RANGE, '0, KEY_MAX, KEY_MAX, CNT_W'(1)));
        send_item(make_item(CMD_RANGE, '0, '0, '0, '1));
        send_item(make_item(CMD_RANGE, '0, KEY_MAX, '0, '1));
        wait_idle();
        // a count beyond the table depth must act as the full depth
        write_count('1);
        send_item(make_item(CMD_FIND, '0, KEY_MAX, '0, '0));
        send_item(make_item(CMD_RANGE, '0, '0, KEY_MAX, '1));
        wait_idle();
    endtask

    task automatic test_edge_ranges();
        send_item(make_item(CMD_WRITE, IDX_W'(0), KEY_WIDTH'(100), '0, '0));
        send_item(make_item(CMD_WRITE, IDX_W'(1), KEY_WIDTH'(200), '0, '0));
        wait_idle();
        write_count(CNT_W'(2));
        send_item(make_item(CMD_RANGE, '0, KEY_WIDTH'(300), KEY_WIDTH'(400), '1));
        send_item(make_item(CMD_RANGE, '0, KEY_WIDTH'(10), KEY_WIDTH'(50), '1));
        send_item(make_item(CMD_RANGE, '0, KEY_WIDTH'(150), KEY_WIDTH'(160), '1));
        send_item(make_item(CMD_RANGE, '0, KEY_WIDTH'(100), KEY_WIDTH'(200), CNT_W'(1)));
        send_item(make_item(CMD_FIND, '0, KEY_WIDTH'(200), '0, '0));
        send_item(make_item(CMD_FIND, '0, KEY_WIDTH'(150), '0, '0));
        wait_idle();
        write_count(CNT_W'(1));
        send_item(make_item(CMD_FIND, '0, KEY_WIDTH'(100), '0, '0));
        send_item(make_item(CMD_RANGE, '0, '0, KEY_MAX, '0));
        wait_idle();
        // out-of-order table: results follow the midpoint steps all the same
        send_item(make_item(CMD_WRITE, IDX_W'(0), KEY_WIDTH'(50), '0, '0));
        send_item(make_item(CMD_WRITE, IDX_W'(1), KEY_WIDTH'(10), '0, '0));
        send_item(make_item(CMD_WRITE, IDX_W'(2), KEY_WIDTH'(40), '0, '0));
        send_item(make_item(CMD_WRITE, IDX_W'(3), KEY_WIDTH'(20), '0, '0));
        wait_idle();
        write_count(CNT_W'(4));
        send_item(make_item(CMD_FIND, '0, KEY_WIDTH'(10), '0, '0));
        send_item(make_item(CMD_FIND, '0, KEY_WIDTH'(20), '0, '0));
        send_item(make_item(CMD_RANGE, '0, KEY_WIDTH'(15), KEY_WIDTH'(45), CNT_W'(5)));
        wait_idle();
    endtask

    // Hold the output long enough for the unit to fill up and stall its input.
    task automatic test_backpressure();
        set_idling(0, 0);
        load_prefix(16, 1'b1);
        wait_idle();
        write_count(CNT_W'(16));
        fork
            begin
                @(posedge clk);
                hold_output = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            begin
                repeat (12) send_item(random_lookup(CMD_FIND));
                in_valid <= 1'b0;
            end
        join
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int mode, pick, n;
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       set_idling(0, 0);
                1:       set_idling(65, 0);
                2:       set_idling(0, 65);
                default: set_idling(32, 32);
            endcase
            repeat (4) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)      n = 0;
                else if (pick == 1) n = 1;
                else                n = $urandom_range(1, (pick < 6) ? 64 : 12);
                write_count(CNT_W'(n));
                if (n > 0 && n < TABLE_DEPTH) load_prefix(n, $urandom_range(0, 9) != 0);
                run_random_batch(18);
                wait_idle();
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        shadow_count   = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_output    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_full_table();
        test_edge_ranges();
        test_backpressure();
        test_random_traffic();

        if (mismatch_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
